// ===== hdl/a2lut_pkg.sv =====
// ----------------------------------------------------------------------------
// a2lut_pkg
// shared types, constants and the arctangent table for the octant atan2 core
// ----------------------------------------------------------------------------
package a2lut_pkg;

  localparam int unsigned CompW  = 8;  // width of dx and dy
  localparam int unsigned MagW   = 8;  // magnitude 0..128
  localparam int unsigned RemW   = 9;  // partial remainder, up to 2*major
  localparam int unsigned QuoW   = 6;  // ratio 0..32
  localparam int unsigned AngleW = 8;
  localparam int unsigned StepsPerStage = 3;

  localparam logic [AngleW-1:0] ZeroAngle = 8'd255;

  // octant base in units of 64; base 256 wraps to 0
  localparam logic [1:0] Base0   = 2'd0;
  localparam logic [1:0] Base64  = 2'd1;
  localparam logic [1:0] Base128 = 2'd2;
  localparam logic [1:0] Base192 = 2'd3;

  typedef struct packed {
    logic              zero;
    logic [1:0]        base;
    logic              sub;
    logic [MagW-1:0]   major;
    logic [RemW-1:0]   rem;
    logic [QuoW-1:0]   quo;
  } a2lut_work_t;

  // arctangent of q/32 scaled to 1/8 turn = 32
  function automatic logic [QuoW-1:0] arc_lut(input logic [QuoW-1:0] q);
    logic [QuoW-1:0] v;
    case (q)
      6'd0:  v = 6'd0;
      6'd1:  v = 6'd1;
      6'd2:  v = 6'd3;
      6'd3:  v = 6'd4;
      6'd4:  v = 6'd5;
      6'd5:  v = 6'd6;
      6'd6:  v = 6'd8;
      6'd7:  v = 6'd9;
      6'd8:  v = 6'd10;
      6'd9:  v = 6'd11;
      6'd10: v = 6'd12;
      6'd11: v = 6'd13;
      6'd12: v = 6'd15;
      6'd13: v = 6'd16;
      6'd14: v = 6'd17;
      6'd15: v = 6'd18;
      6'd16: v = 6'd19;
      6'd17: v = 6'd20;
      6'd18: v = 6'd21;
      6'd19: v = 6'd22;
      6'd20: v = 6'd23;
      6'd21: v = 6'd24;
      6'd22: v = 6'd25;
      6'd23: v = 6'd25;
      6'd24: v = 6'd26;
      6'd25: v = 6'd27;
      6'd26: v = 6'd28;
      6'd27: v = 6'd29;
      6'd28: v = 6'd29;
      6'd29: v = 6'd30;
      6'd30: v = 6'd31;
      6'd31: v = 6'd31;
      6'd32: v = 6'd32;
      default: v = 6'd32;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/atan2_binary_angle_octant_lut_core.sv =====
// ----------------------------------------------------------------------------
// atan2_binary_angle_octant_lut_core
// direction of a signed 8-bit vector as an 8-bit binary angle
// ----------------------------------------------------------------------------
// Give a beat with start high and the vector on dx_i/dy_i; one result beat
// follows out of the last register stage with valid_o high for a single cycle,
// carrying angle_o (0 along +y, 64 along +x, 256 per turn) and zero_vector_o.
// A new vector may be given in every cycle: busy stays low, since the four
// register stages (octant sort, two three-bit division stages, table and
// base add) each pass one beat per cycle and the receiver cannot stall.
// A zero vector returns angle 255 with zero_vector_o set.
module atan2_binary_angle_octant_lut_core
  import a2lut_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CompW-1:0]  dx_i,
  input  logic [CompW-1:0]  dy_i,
  output logic              valid_o,
  output logic [AngleW-1:0] angle_o,
  output logic              zero_vector_o
);

  // stage valids and working words
  logic        sort_valid, div_a_valid, div_b_valid;
  a2lut_work_t sort_work, div_a_work, div_b_work;

  // fully pipelined, never holds off a beat
  assign busy = 1'b0;

  // stage 1: signs, magnitudes, octant base and direction
  a2lut_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .dx_i    (dx_i),
    .dy_i    (dy_i),
    .valid_o (sort_valid),
    .work_o  (sort_work)
  );

  // stage 2: quotient bits 5..3 of 32*minor/major
  a2lut_div u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sort_valid),
    .work_i  (sort_work),
    .valid_o (div_a_valid),
    .work_o  (div_a_work)
  );

  // stage 3: quotient bits 2..0
  a2lut_div u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_a_valid),
    .work_i  (div_a_work),
    .valid_o (div_b_valid),
    .work_o  (div_b_work)
  );

  // stage 4: arctangent table, base add or subtract, result register
  a2lut_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (div_b_valid),
    .work_i        (div_b_work),
    .valid_o       (valid_o),
    .angle_o       (angle_o),
    .zero_vector_o (zero_vector_o)
  );

endmodule

// ===== hdl/a2lut_sort.sv =====
// ----------------------------------------------------------------------------
// a2lut_sort
// octant classification: magnitudes, minor/major, base and direction
// ----------------------------------------------------------------------------
module a2lut_sort
  import a2lut_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [CompW-1:0]   dx_i,
  input  logic [CompW-1:0]   dy_i,
  output logic               valid_o,
  output a2lut_work_t        work_o
);

  logic [MagW-1:0] ax, ay;
  logic            x_neg, y_neg;
  logic            y_ge_x, x_ge_y;
  logic            take_x_minor;
  a2lut_work_t     work_d, work_q;
  logic            valid_q;

  assign x_neg  = dx_i[CompW-1];
  assign y_neg  = dy_i[CompW-1];
  // -(-128) wraps to 8'h80, which reads as 128 unsigned
  assign ax     = x_neg ? (~dx_i + 8'd1) : dx_i;
  assign ay     = y_neg ? (~dy_i + 8'd1) : dy_i;
  assign y_ge_x = (ay >= ax);
  assign x_ge_y = (ax >= ay);

  always_comb begin
    work_d      = '0;
    work_d.zero = (dx_i == '0) && (dy_i == '0);
    take_x_minor = 1'b0;
    case ({x_neg, y_neg})
      2'b00: begin
        take_x_minor = y_ge_x;
        work_d.base  = y_ge_x ? Base0 : Base64;
        work_d.sub   = !y_ge_x;
      end
      2'b01: begin
        take_x_minor = !x_ge_y;
        work_d.base  = x_ge_y ? Base64 : Base128;
        work_d.sub   = !x_ge_y;
      end
      2'b11: begin
        take_x_minor = y_ge_x;
        work_d.base  = y_ge_x ? Base128 : Base192;
        work_d.sub   = !y_ge_x;
      end
      2'b10: begin
        take_x_minor = !x_ge_y;
        work_d.base  = x_ge_y ? Base192 : Base0;
        work_d.sub   = !x_ge_y;
      end
      default: begin
        take_x_minor = 1'b0;
      end
    endcase
    work_d.major = take_x_minor ? ay : ax;
    work_d.rem   = {1'b0, (take_x_minor ? ax : ay)};
    work_d.quo   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== hdl/a2lut_div.sv =====
// ----------------------------------------------------------------------------
// a2lut_div
// restoring division stage, three quotient bits of 32*minor/major per stage
// ----------------------------------------------------------------------------
module a2lut_div
  import a2lut_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  a2lut_work_t   work_i,
  output logic          valid_o,
  output a2lut_work_t   work_o
);

  a2lut_work_t   work_d, work_q;
  logic          valid_q;
  logic [RemW-1:0] r;
  logic [RemW-1:0] diff;
  logic          quo_bit;

  // compare, subtract, then shift: the remainder stays below 2*major
  always_comb begin
    work_d  = work_i;
    r       = work_i.rem;
    diff    = '0;
    quo_bit = 1'b0;
    for (int i = 0; i < StepsPerStage; i++) begin
      quo_bit    = (r >= {1'b0, work_i.major});
      diff       = quo_bit ? (r - {1'b0, work_i.major}) : r;
      r          = {diff[RemW-2:0], 1'b0};
      work_d.quo = {work_d.quo[QuoW-2:0], quo_bit};
    end
    work_d.rem = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== hdl/a2lut_finish.sv =====
// ----------------------------------------------------------------------------
// a2lut_finish
// table lookup, octant base add or subtract, zero vector override
// ----------------------------------------------------------------------------
module a2lut_finish
  import a2lut_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  a2lut_work_t       work_i,
  output logic              valid_o,
  output logic [AngleW-1:0] angle_o,
  output logic              zero_vector_o
);

  logic [AngleW-1:0] base8, lut8, angle_d, angle_q;
  logic              zero_q, valid_q;

  assign base8 = {work_i.base, 6'b0};
  assign lut8  = {2'b0, arc_lut(work_i.quo)};

  always_comb begin
    if (work_i.zero) begin
      angle_d = ZeroAngle;
    end else if (work_i.sub) begin
      angle_d = base8 - lut8;
    end else begin
      angle_d = base8 + lut8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    zero_q  <= work_i.zero;
  end

  assign valid_o       = valid_q;
  assign angle_o       = angle_q;
  assign zero_vector_o = zero_q;

endmodule
